[rtl/dfsm_pkg.sv]
// Package with shared types, constants and layout tables of the frame sector mapper.
`timescale 1ns / 1ps

package dfsm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_LAYOUT_MODE = 2'd0;
    localparam logic [1:0] REG_AREA_START  = 2'd1;
    localparam logic [1:0] REG_HEADER      = 2'd2;

    localparam logic MODE_3_IN_14 = 1'b0;
    localparam logic MODE_3_IN_16 = 1'b1;

    localparam logic [32:0] RECIP_3 = 33'h0AAAAAAAB;

    // A classified frame waiting for the back end.
    typedef struct packed {
        logic [31:0] scaled_block;
        logic [1:0]  pos;
    } job_t;

    function automatic logic [2:0] frame_pieces(input logic mode, input logic [1:0] pos);
        logic [2:0] res;
        if (mode == MODE_3_IN_16) begin
            res = 3'd6;
        end
        else if (pos == 2'd1) begin
            res = 3'd6;
        end
        else begin
            res = 3'd5;
        end
        return res;
    endfunction

    function automatic logic [3:0] sector_add(input logic mode, input logic [1:0] pos);
        logic [3:0] res;
        unique case (pos)
            2'd1:    res = (mode == MODE_3_IN_16) ? 4'd5 : 4'd4;
            2'd2:    res = (mode == MODE_3_IN_16) ? 4'd10 : 4'd9;
            default: res = 4'd0;
        endcase
        return res;
    endfunction

    function automatic logic [10:0] piece_offset(input logic mode, input logic [1:0] pos,
                                                 input logic [2:0] piece);
        logic [10:0] res;
        if (mode == MODE_3_IN_16) begin
            res = 11'd284;
            if (piece == 3'd0) begin
                unique case (pos)
                    2'd1:    res = 11'd872;
                    2'd2:    res = 11'd1460;
                    default: res = 11'd284;
                endcase
            end
        end
        else begin
            res = 11'd32;
            if (piece == 3'd0) begin
                unique case (pos)
                    2'd1:    res = 11'd1376;
                    2'd2:    res = 11'd704;
                    default: res = 11'd32;
                endcase
            end
        end
        return res;
    endfunction

    function automatic logic [10:0] piece_length(input logic mode, input logic [1:0] pos,
                                                 input logic [2:0] piece);
        logic [10:0] res;
        if (mode == MODE_3_IN_16) begin
            res = 11'd1764;
            unique case (pos)
                2'd0:    if (piece == 3'd5) res = 11'd588;
                2'd1:    if (piece == 3'd0 || piece == 3'd5) res = 11'd1176;
                2'd2:    if (piece == 3'd0) res = 11'd588;
                default: res = 11'd1764;
            endcase
        end
        else begin
            res = 11'd2016;
            unique case (pos)
                2'd0:    if (piece == 3'd4) res = 11'd1344;
                2'd1:    if (piece == 3'd0 || piece == 3'd5) res = 11'd672;
                2'd2:    if (piece == 3'd0) res = 11'd1344;
                default: res = 11'd2016;
            endcase
        end
        return res;
    endfunction

endpackage

[rtl/dsd_frame_sector_mapper.sv]
// Top level of the plain DSD frame to sector mapper with its register file.
//
// A frame number enters on the frame channel (frame_valid, frame_stall, frame_number).
// For each frame the block issues five or six read descriptors on the descriptor
// channel (desc_valid, desc_stall and the payload ports), one per sector piece, in
// piece order, with last set on the final piece.
// The front end divides the frame number by three, registers the result and places it
// in a two-entry queue; the back end issues one descriptor per cycle while the
// receiver does not stall. The first descriptor of a frame passes the front-end
// register, the queue and the output register. The back end's piece sequencer walks
// the five or six pieces of each frame; frames are taken back to back while the
// back end works.
// The registers layout_mode, area_start_sector and header_bytes sit on the APB port;
// the user must write them only while no transaction is in flight, the block does not enforce it.
// Reset clears the registers, the queue and all valid flags.
// When the receiver stalls, the current descriptor holds, the queue fills and then
// frame_stall rises until space frees up.
`timescale 1ns / 1ps

module dsd_frame_sector_mapper #(
    parameter int QUEUE_DEPTH = dfsm_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dfsm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        frame_valid,
    output logic                        frame_stall,
    input  logic [31:0]                 frame_number,
    output logic                        desc_valid,
    input  logic                        desc_stall,
    output logic [31:0]                 sector_address,
    output logic [11:0]                 byte_offset,
    output logic [10:0]                 byte_count,
    output logic [13:0]                 dest_offset,
    output logic [2:0]                  piece_index,
    output logic [2:0]                  sectors_in_frame,
    output logic                        last
);

    logic           layout_mode_reg;
    logic [31:0]    area_start_reg;
    logic [8:0]     header_bytes_reg;
    logic           cfg_write;
    logic [1:0]     reg_sel;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_nonempty;
    dfsm_pkg::job_t push_job;
    dfsm_pkg::job_t head_job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            layout_mode_reg  <= 1'b0;
            area_start_reg   <= '0;
            header_bytes_reg <= '0;
        end
        else if (cfg_write) begin
            unique case (reg_sel)
                dfsm_pkg::REG_LAYOUT_MODE: layout_mode_reg  <= pwdata[0];
                dfsm_pkg::REG_AREA_START:  area_start_reg   <= pwdata;
                dfsm_pkg::REG_HEADER:      header_bytes_reg <= pwdata[8:0];
                default:                   layout_mode_reg  <= layout_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            dfsm_pkg::REG_LAYOUT_MODE: prdata = {31'd0, layout_mode_reg};
            dfsm_pkg::REG_AREA_START:  prdata = area_start_reg;
            dfsm_pkg::REG_HEADER:      prdata = {23'd0, header_bytes_reg};
            default:                   prdata = '0;
        endcase
    end

    dfsm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .layout_mode  (layout_mode_reg),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_number (frame_number),
        .push         (push),
        .push_job     (push_job),
        .queue_full   (queue_full)
    );

    dfsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .nonempty (queue_nonempty),
        .head_job (head_job)
    );

    dfsm_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .layout_mode       (layout_mode_reg),
        .area_start_sector (area_start_reg),
        .header_bytes      (header_bytes_reg),
        .queue_nonempty    (queue_nonempty),
        .head_job          (head_job),
        .pop               (pop),
        .desc_valid        (desc_valid),
        .desc_stall        (desc_stall),
        .sector_address    (sector_address),
        .byte_offset       (byte_offset),
        .byte_count        (byte_count),
        .dest_offset       (dest_offset),
        .piece_index       (piece_index),
        .sectors_in_frame  (sectors_in_frame),
        .last              (last)
    );

endmodule

[rtl/dfsm_front.sv]
// Front end: splits the frame number into block and position and scales the block.
`timescale 1ns / 1ps

module dfsm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               layout_mode,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  logic [31:0]        frame_number,
    output logic               push,
    output dfsm_pkg::job_t     push_job,
    input  logic               queue_full
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_frame_reg;
    logic [31:0] s1_block_reg;
    logic [64:0] product;
    logic        accept;
    logic [31:0] block_x3;
    logic [31:0] block_x16;
    logic [31:0] block_x2;

    assign frame_stall = s1_valid_reg && queue_full;
    assign accept      = frame_valid && !frame_stall;
    assign push        = s1_valid_reg && !queue_full;

    // Division by three through the reciprocal; the upper bits hold the quotient.
    assign product = {32'd0, frame_number} * {32'd0, dfsm_pkg::RECIP_3};

    always_comb
    begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end
        else if (push) begin
            s1_valid_next = 1'b0;
        end
        else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_frame_reg <= frame_number;
            s1_block_reg <= {1'b0, product[63:33]};
        end
    end

    assign block_x2  = {s1_block_reg[30:0], 1'b0};
    assign block_x3  = block_x2 + s1_block_reg;
    assign block_x16 = {s1_block_reg[27:0], 4'd0};

    always_comb
    begin
        push_job.pos = s1_frame_reg[1:0] - block_x3[1:0];
        if (layout_mode == dfsm_pkg::MODE_3_IN_16) begin
            push_job.scaled_block = block_x16;
        end
        else begin
            push_job.scaled_block = block_x16 - block_x2;
        end
    end

endmodule

[rtl/dfsm_queue.sv]
// Short queue of classified frames between the front and back ends.
`timescale 1ns / 1ps

module dfsm_queue #(
    parameter int DEPTH = dfsm_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dfsm_pkg::job_t     push_job,
    output logic               full,
    input  logic               pop,
    output logic               nonempty,
    output dfsm_pkg::job_t     head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dfsm_pkg::job_t    entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head_job = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/dfsm_back.sv]
// Back end: walks the pieces of one frame and issues one read descriptor per cycle while the receiver does not stall.
`timescale 1ns / 1ps

module dfsm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               layout_mode,
    input  logic [31:0]        area_start_sector,
    input  logic [8:0]         header_bytes,
    input  logic               queue_nonempty,
    input  dfsm_pkg::job_t     head_job,
    output logic               pop,
    output logic               desc_valid,
    input  logic               desc_stall,
    output logic [31:0]        sector_address,
    output logic [11:0]        byte_offset,
    output logic [10:0]        byte_count,
    output logic [13:0]        dest_offset,
    output logic [2:0]         piece_index,
    output logic [2:0]         sectors_in_frame,
    output logic               last
);

    logic        busy_reg;
    logic [2:0]  piece_reg;
    logic [1:0]  pos_reg;
    logic        valid_reg;
    logic [31:0] addr_reg;
    logic [11:0] offset_reg;
    logic [10:0] count_reg;
    logic [13:0] dest_reg;
    logic [2:0]  index_reg;
    logic [2:0]  sectors_reg;
    logic        last_reg;

    logic        slot_free;
    logic        issue_first;
    logic        issue;
    logic [1:0]  cur_pos;
    logic [2:0]  cur_piece;
    logic [2:0]  cur_sectors;
    logic        cur_last;
    logic [31:0] cur_addr;
    logic [13:0] cur_dest;

    assign slot_free   = !valid_reg || !desc_stall;
    assign issue_first = !busy_reg && queue_nonempty && slot_free;
    assign issue       = issue_first || (busy_reg && slot_free);
    assign pop         = issue_first;

    assign cur_pos     = busy_reg ? pos_reg : head_job.pos;
    assign cur_piece   = busy_reg ? piece_reg : 3'd0;
    assign cur_sectors = dfsm_pkg::frame_pieces(layout_mode, cur_pos);
    assign cur_last    = (cur_piece == cur_sectors - 3'd1);

    // Later pieces follow the previous descriptor still held in the output register.
    always_comb
    begin
        if (busy_reg) begin
            cur_addr = addr_reg + 32'd1;
            cur_dest = dest_reg + {3'd0, count_reg};
        end
        else begin
            cur_addr = area_start_sector + head_job.scaled_block
                       + {28'd0, dfsm_pkg::sector_add(layout_mode, cur_pos)};
            cur_dest = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            piece_reg <= '0;
            pos_reg   <= '0;
        end
        else begin
            if (issue) begin
                valid_reg <= 1'b1;
                busy_reg  <= !cur_last;
                piece_reg <= cur_piece + 3'd1;
                pos_reg   <= cur_pos;
            end
            else if (!desc_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue) begin
            addr_reg    <= cur_addr;
            offset_reg  <= {3'd0, header_bytes}
                           + {1'b0, dfsm_pkg::piece_offset(layout_mode, cur_pos, cur_piece)};
            count_reg   <= dfsm_pkg::piece_length(layout_mode, cur_pos, cur_piece);
            dest_reg    <= cur_dest;
            index_reg   <= cur_piece;
            sectors_reg <= cur_sectors;
            last_reg    <= cur_last;
        end
    end

    assign desc_valid       = valid_reg;
    assign sector_address   = addr_reg;
    assign byte_offset      = offset_reg;
    assign byte_count       = count_reg;
    assign dest_offset      = dest_reg;
    assign piece_index      = index_reg;
    assign sectors_in_frame = sectors_reg;
    assign last             = last_reg;

endmodule

[rtl/dfsm_checker.sv]
// Port-level checker of the frame sector mapper and its bind statement.
`timescale 1ns / 1ps

module dfsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        desc_valid,
    input logic        desc_stall,
    input logic [31:0] sector_address,
    input logic [13:0] dest_offset,
    input logic [10:0] byte_count,
    input logic [2:0]  piece_index,
    input logic [2:0]  sectors_in_frame,
    input logic        last
);

    logic desc_accept;

    assign desc_accept = desc_valid && !desc_stall;

    // A stalled descriptor transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && desc_stall |=> desc_valid && $stable(sector_address)
            && $stable(piece_index) && $stable(last))
        else $error("stalled descriptor changed");

    // The last flag marks exactly the final piece of the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> (last == (piece_index + 3'd1 == sectors_in_frame))
            && (sectors_in_frame == 3'd5 || sectors_in_frame == 3'd6))
        else $error("piece index and last flag disagree");

    // Pieces of one frame follow without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_accept && !last |=> desc_valid
            && piece_index == $past(piece_index) + 3'd1
            && sectors_in_frame == $past(sectors_in_frame))
        else $error("gap or index jump inside a frame");

    // Consecutive pieces sit in consecutive sectors and consecutive frame bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_accept && !last |=> sector_address == $past(sector_address) + 32'd1
            && dest_offset == $past(dest_offset) + {3'd0, $past(byte_count)})
        else $error("piece address or destination not contiguous");

endmodule

bind dsd_frame_sector_mapper dfsm_checker u_dfsm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .desc_valid       (desc_valid),
    .desc_stall       (desc_stall),
    .sector_address   (sector_address),
    .dest_offset      (dest_offset),
    .byte_count       (byte_count),
    .piece_index      (piece_index),
    .sectors_in_frame (sectors_in_frame),
    .last             (last)
);

[tb/tb.sv]
// Testbench for the frame sector mapper: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [dfsm_pkg::ADDR_W-1:0] ADDR_MODE   = {dfsm_pkg::REG_LAYOUT_MODE, 2'b00};
    localparam logic [dfsm_pkg::ADDR_W-1:0] ADDR_AREA   = {dfsm_pkg::REG_AREA_START, 2'b00};
    localparam logic [dfsm_pkg::ADDR_W-1:0] ADDR_HEADER = {dfsm_pkg::REG_HEADER, 2'b00};
    localparam logic [dfsm_pkg::ADDR_W-1:0] ADDR_UNUSED = 4'hC;

    // Layout tables indexed by mode, position in the block and piece.
    localparam int unsigned BLOCK_STRIDE [2] = '{14, 16};
    localparam int unsigned PIECE_TOTAL [2][3] = '{'{5, 6, 5}, '{6, 6, 6}};
    localparam int unsigned SECTOR_SKIP [2][3] = '{'{0, 4, 9}, '{0, 5, 10}};
    localparam int unsigned TABLE_OFFSET [2][3][6] = '{
        '{'{32, 32, 32, 32, 32, 0}, '{1376, 32, 32, 32, 32, 32}, '{704, 32, 32, 32, 32, 0}},
        '{'{284, 284, 284, 284, 284, 284}, '{872, 284, 284, 284, 284, 284},
          '{1460, 284, 284, 284, 284, 284}}
    };
    localparam int unsigned PIECE_BYTES [2][3][6] = '{
        '{'{2016, 2016, 2016, 2016, 1344, 0}, '{672, 2016, 2016, 2016, 2016, 672},
          '{1344, 2016, 2016, 2016, 2016, 0}},
        '{'{1764, 1764, 1764, 1764, 1764, 588}, '{1176, 1764, 1764, 1764, 1764, 1176},
          '{588, 1764, 1764, 1764, 1764, 1764}}
    };

    typedef struct packed {
        logic [31:0] sector_address;
        logic [11:0] byte_offset;
        logic [10:0] byte_count;
        logic [13:0] dest_offset;
        logic [2:0]  piece_index;
        logic [2:0]  sectors_in_frame;
        logic        last;
    } read_desc_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dfsm_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          frame_valid;
    logic                          frame_stall;
    logic [31:0]                   frame_number;
    logic                          desc_valid;
    logic                          desc_stall = 1'b0;
    logic [31:0]                   sector_address;
    logic [11:0]                   byte_offset;
    logic [10:0]                   byte_count;
    logic [13:0]                   dest_offset;
    logic [2:0]                    piece_index;
    logic [2:0]                    sectors_in_frame;
    logic                          last;

    logic                          layout_sel;
    logic [31:0]                   area_base;
    logic [8:0]                    header_len;

    read_desc_t          pending_descs[$];
    int                  fail_count = 0;
    int                  quiet_cycles = 0;
    int                  sender_idle_pct;
    int                  receiver_stall_pct;

    dsd_frame_sector_mapper DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .frame_valid      (frame_valid),
        .frame_stall      (frame_stall),
        .frame_number     (frame_number),
        .desc_valid       (desc_valid),
        .desc_stall       (desc_stall),
        .sector_address   (sector_address),
        .byte_offset      (byte_offset),
        .byte_count       (byte_count),
        .dest_offset      (dest_offset),
        .piece_index      (piece_index),
        .sectors_in_frame (sectors_in_frame),
        .last             (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Computes the descriptors of one frame under the current register values.
    task automatic queue_frame_descs(input logic [31:0] fnum);
        int unsigned m;
        int unsigned blk;
        int unsigned pos;
        int unsigned dest;
        logic [31:0] base;
        read_desc_t  d;
        m    = layout_sel;
        blk  = fnum / 3;
        pos  = fnum % 3;
        base = area_base + blk * BLOCK_STRIDE[m] + SECTOR_SKIP[m][pos];
        dest = 0;
        for (int unsigned i = 0; i < PIECE_TOTAL[m][pos]; i++)
        begin
            d.sector_address   = base + i;
            d.byte_offset      = 12'(header_len + TABLE_OFFSET[m][pos][i]);
            d.byte_count       = 11'(PIECE_BYTES[m][pos][i]);
            d.dest_offset      = 14'(dest);
            d.piece_index      = 3'(i);
            d.sectors_in_frame = 3'(PIECE_TOTAL[m][pos]);
            d.last             = (i + 1 == PIECE_TOTAL[m][pos]);
            pending_descs.push_back(d);
            dest += PIECE_BYTES[m][pos][i];
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        read_desc_t d;
        if (rst_n && desc_valid && !desc_stall)
        begin
            if (pending_descs.size() == 0)
            begin
                $error("descriptor transaction with no frame outstanding");
                fail_count++;
            end
            else
            begin
                d = pending_descs.pop_front();
                check_field("sector_address", d.sector_address, sector_address);
                check_field("byte_offset", 32'(d.byte_offset), 32'(byte_offset));
                check_field("byte_count", 32'(d.byte_count), 32'(byte_count));
                check_field("dest_offset", 32'(d.dest_offset), 32'(dest_offset));
                check_field("piece_index", 32'(d.piece_index), 32'(piece_index));
                check_field("sectors_in_frame", 32'(d.sectors_in_frame),
                            32'(sectors_in_frame));
                check_field("last", 32'(d.last), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        desc_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (desc_valid && !desc_stall) || psel || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_frame(input logic [31:0] fnum);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
            begin
                @(posedge clk);
            end
        end
        frame_valid  <= 1'b1;
        frame_number <= fnum;
        @(posedge clk);
        while (frame_stall)
        begin
            @(posedge clk);
        end
        queue_frame_descs(fnum);
    endtask

    task automatic wait_for_drain();
        frame_valid <= 1'b0;
        while (pending_descs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [dfsm_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (addr)
            ADDR_MODE:   layout_sel = data[0];
            ADDR_AREA:   area_base = data;
            ADDR_HEADER: header_len = data[8:0];
            default:     ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers change only once the block has emptied.
    task automatic set_layout(input logic mode, input logic [31:0] area,
                              input logic [31:0] header);
        wait_for_drain();
        repeat (4) @(posedge clk);
        write_reg(ADDR_MODE, {31'd0, mode});
        write_reg(ADDR_AREA, area);
        write_reg(ADDR_HEADER, header);
    endtask

    function automatic logic [31:0] random_frame();
        logic [31:0] fnum;
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4)
        begin
            fnum = $urandom_range(299);
        end
        else if (sel < 7)
        begin
            fnum = 32'hFFFF_FFFF - $urandom_range(299);
        end
        else
        begin
            fnum = $urandom;
        end
        return fnum;
    endfunction

    task automatic test_reset_layout();
        for (int i = 0; i < 3; i++)
        begin
            send_frame(32'(i));
        end
    endtask

    task automatic test_layout_extremes();
        set_layout(dfsm_pkg::MODE_3_IN_16, 32'hFFFF_FFF8, 32'd511);
        send_frame(32'd3);
        send_frame(32'd4);
        send_frame(32'd5);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFE);
        send_frame(32'hFFFF_FFFD);
        set_layout(dfsm_pkg::MODE_3_IN_14, 32'hFFFF_FFFF, 32'd511);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFE);
        send_frame(32'hFFFF_FFFD);
        send_frame(32'd6);
        send_frame(32'd7);
    endtask

    task automatic test_register_masking();
        wait_for_drain();
        repeat (4) @(posedge clk);
        write_reg(ADDR_MODE, 32'hFFFF_FFFF);
        write_reg(ADDR_MODE, 32'hFFFF_FFFE);
        write_reg(ADDR_AREA, 32'h7FFF_FFFF);
        write_reg(ADDR_HEADER, 32'hFFFF_FE05);
        write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_frame(32'd9);
        send_frame(32'd10);
        send_frame(32'd11);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_frames, input bit pause_midway);
        logic [31:0] area;
        logic [31:0] header;
        area   = ($urandom_range(1) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(999);
        header = ($urandom_range(1) == 0) ? $urandom : $urandom_range(511);
        set_layout(1'($urandom_range(1)), area, header);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n_frames; i++)
        begin
            if (pause_midway && i == n_frames / 2)
            begin
                wait_for_drain();
            end
            send_frame(random_frame());
        end
        wait_for_drain();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        frame_valid        = 1'b0;
        frame_number       = '0;
        layout_sel         = dfsm_pkg::MODE_3_IN_14;
        area_base          = '0;
        header_len         = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_layout();
        test_layout_extremes();
        test_register_masking();
        test_random_traffic(0, 0, 28, 1'b0);
        test_random_traffic(52, 0, 28, 1'b1);
        test_random_traffic(0, 52, 28, 1'b0);
        test_random_traffic(15, 15, 28, 1'b0);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/dfsm_pkg.sv
rtl/dfsm_front.sv
rtl/dfsm_queue.sv
rtl/dfsm_back.sv
rtl/dsd_frame_sector_mapper.sv
rtl/dfsm_checker.sv
tb/tb.sv
